>>> hw/rtl/kme_pkg.sv
// Package for the key matrix event generator: payload structs, keycode ROM,
// hold state machine type, command queue entry and register indexes.
// No dependencies; every other RTL file imports it.
`default_nettype none

package kme_pkg;

  // Input item: one key sample.
  typedef struct packed {
    logic        opcode;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        pressed;
    logic [31:0] now_ms;
  } in_item_t;

  // Result item: one reported event.
  typedef struct packed {
    logic       event_valid;
    logic [7:0] keycode;
    logic [2:0] ev_state;
    logic       power_on_request;
    logic       last;
  } out_item_t;

  // Sample kinds.
  localparam logic OP_MATRIX = 1'b0;
  localparam logic OP_POWER  = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVER_LOADED = 2'd2;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [7:0]  HOLD_TIME_RST = 8'd30;
  localparam logic [15:0] LONG_HOLD_RST = 16'd1000;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic [7:0]  hold_time_tens_ms;
    logic [15:0] pwr_hold_ms;
    logic        driver_loaded;
  } cfg_t;

  // Keycodes with special handling.
  localparam logic [7:0] KC_NONE   = 8'd0;
  localparam logic [7:0] KC_LSHIFT = 8'd42;
  localparam logic [7:0] KC_RSHIFT = 8'd54;
  localparam logic [7:0] KC_LALT   = 8'd56;
  localparam logic [7:0] KC_RALT   = 8'd100;
  localparam logic [7:0] KC_POWER  = 8'd116;

  // Reported key state codes.
  localparam logic [2:0] KS_IDLE     = 3'd0;
  localparam logic [2:0] KS_PRESSED  = 3'd1;
  localparam logic [2:0] KS_HOLD     = 3'd2;
  localparam logic [2:0] KS_LONG     = 3'd3;
  localparam logic [2:0] KS_RELEASED = 3'd4;

  // Hold state machines: four modifiers and the power button.
  localparam int NHOLD     = 5;
  localparam int HOLD_IDX_W = 3;
  localparam logic [HOLD_IDX_W-1:0] HIDX_LSHIFT = 3'd0;
  localparam logic [HOLD_IDX_W-1:0] HIDX_RSHIFT = 3'd1;
  localparam logic [HOLD_IDX_W-1:0] HIDX_LALT   = 3'd2;
  localparam logic [HOLD_IDX_W-1:0] HIDX_RALT   = 3'd3;
  localparam logic [HOLD_IDX_W-1:0] HIDX_POWER  = 3'd4;

  typedef enum logic [4:0] {
    HS_IDLE     = 5'b00001,
    HS_PRESSED  = 5'b00010,
    HS_HOLD     = 5'b00100,
    HS_LONG     = 5'b01000,
    HS_RELEASED = 5'b10000
  } hold_st_t;

  // Keycode ROM, row major with six columns per row.
  localparam int MAP_SIZE = 42;
  localparam logic [7:0] KEYMAP [0:MAP_SIZE-1] = '{
    8'd127, 8'd17,  8'd34, 8'd31, 8'd38,  8'd35,
    8'd0,   8'd16,  8'd19, 8'd18, 8'd24,  8'd22,
    8'd134, 8'd11,  8'd33, 8'd42, 8'd37,  8'd36,
    8'd0,   8'd57,  8'd46, 8'd44, 8'd50,  8'd49,
    8'd130, 8'd100, 8'd20, 8'd32, 8'd23,  8'd21,
    8'd1,   8'd56,  8'd47, 8'd45, 8'd113, 8'd48,
    8'd0,   8'd30,  8'd54, 8'd25, 8'd14,  8'd28
  };

  // What the back end has to emit for one accepted sample.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_POR   = 2'd2,
    CMD_PULSE = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] keycode;
    logic [2:0] ev_state;
  } cmd_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Reported code of a hold state.
  function automatic logic [2:0] hold_st_code(hold_st_t st);
    logic [2:0] code;
    case (st)
      HS_PRESSED:  code = KS_PRESSED;
      HS_HOLD:     code = KS_HOLD;
      HS_LONG:     code = KS_LONG;
      HS_RELEASED: code = KS_RELEASED;
      default:     code = KS_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kme_front.sv
// Front end: accepts key samples, looks up keycodes, advances key state and
// pushes one command per sample into the queue. Depends on kme_pkg.
`default_nettype none

module kme_front #(
  parameter int ROWS = 7,
  parameter int COLS = 6
) (
  input  wire               clk,
  input  wire               rst_n,
  input  kme_pkg::cfg_t     cfg,
  input  wire               in_valid,
  output logic              in_ready,
  input  kme_pkg::in_item_t in_data,
  output logic              push_valid,
  input  wire               push_ready,
  output kme_pkg::cmd_t     push_cmd
);
  import kme_pkg::*;

  localparam int NKEYS     = ROWS * COLS;
  localparam int KEY_IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  logic [NKEYS-1:0]  key_down_r;
  hold_st_t          hold_st_r    [NHOLD];
  logic [31:0]       hold_start_r [NHOLD];

  logic              accept;
  logic              in_range;
  logic [7:0]        pos;
  logic [7:0]        code;
  logic              map_ok;
  logic              is_mod;
  logic [HOLD_IDX_W-1:0] sel;
  logic              fsm_en;
  logic              kd_en;
  logic              kd_cur;
  hold_st_t          cur_st;
  hold_st_t          hold_st_nxt;
  logic [31:0]       held;
  logic [11:0]       hold_thr;
  logic              hold_hit;
  logic              long_hit;
  logic              set_start;
  logic              por;
  logic              pulse;
  logic [2:0]        nxt_code;

  // One sample per cycle as long as the queue has room.
  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  assign push_valid = in_valid;

  // Matrix position and keycode lookup.
  always_comb begin
    in_range = ({2'b00, in_data.row} < 5'(ROWS)) && ({2'b00, in_data.col} < 5'(COLS));
    pos      = 8'({5'b0, in_data.row} * 8'(COLS)) + {5'b0, in_data.col};
    code     = KC_NONE;
    if (pos < 8'(MAP_SIZE)) begin
      code = KEYMAP[pos[5:0]];
    end
    map_ok = (in_data.opcode == OP_MATRIX) && in_range && (code != KC_NONE)
             && (code != KC_POWER);
  end

  // Pick the hold state machine, if any, that this sample drives.
  always_comb begin
    is_mod = 1'b1;
    sel    = HIDX_POWER;
    case (code)
      KC_LSHIFT: sel = HIDX_LSHIFT;
      KC_RSHIFT: sel = HIDX_RSHIFT;
      KC_LALT:   sel = HIDX_LALT;
      KC_RALT:   sel = HIDX_RALT;
      default:   is_mod = 1'b0;
    endcase
    if (in_data.opcode == OP_POWER) begin
      sel = HIDX_POWER;
    end
    fsm_en = (in_data.opcode == OP_POWER) || (map_ok && is_mod);
    kd_en  = map_ok && !is_mod;
    kd_cur = key_down_r[pos[KEY_IDX_W-1:0]];
  end

  // Advance the selected hold state machine.
  always_comb begin
    cur_st      = hold_st_r[sel];
    held        = in_data.now_ms - hold_start_r[sel];
    hold_thr    = {1'b0, cfg.hold_time_tens_ms, 3'b000} + {3'b000, cfg.hold_time_tens_ms, 1'b0};
    hold_hit    = held > {20'b0, hold_thr};
    long_hit    = held > {16'b0, cfg.pwr_hold_ms};
    hold_st_nxt = cur_st;
    set_start   = 1'b0;
    por         = 1'b0;
    pulse       = 1'b0;
    case (cur_st)
      HS_IDLE: begin
        if (in_data.pressed) begin
          hold_st_nxt = HS_PRESSED;
          set_start   = 1'b1;
        end
      end
      HS_PRESSED: begin
        if (hold_hit) begin
          hold_st_nxt = HS_HOLD;
        end else if (!in_data.pressed) begin
          hold_st_nxt = HS_RELEASED;
        end
      end
      HS_HOLD: begin
        if (!in_data.pressed) begin
          hold_st_nxt = HS_RELEASED;
        end else if (sel == HIDX_POWER) begin
          if (!cfg.driver_loaded) begin
            por         = 1'b1;
            hold_st_nxt = HS_LONG;
          end else if (long_hit) begin
            pulse       = 1'b1;
            hold_st_nxt = HS_LONG;
          end
        end
      end
      HS_LONG: begin
        if (!in_data.pressed) begin
          hold_st_nxt = HS_RELEASED;
        end
      end
      default: hold_st_nxt = HS_IDLE;
    endcase
    nxt_code = hold_st_code(hold_st_nxt);
  end

  // Command for the back end.
  always_comb begin
    push_cmd.kind     = CMD_NONE;
    push_cmd.keycode  = code;
    push_cmd.ev_state = KS_IDLE;
    if (in_data.opcode == OP_POWER) begin
      if (pulse) begin
        push_cmd.kind = CMD_PULSE;
      end else if (por) begin
        push_cmd.kind = CMD_POR;
      end
    end else if (fsm_en) begin
      if ((hold_st_nxt != cur_st) && ((hold_st_nxt == HS_PRESSED) ||
          (hold_st_nxt == HS_HOLD) || (hold_st_nxt == HS_RELEASED))) begin
        push_cmd.kind     = CMD_EVENT;
        push_cmd.ev_state = nxt_code;
      end
    end else if (kd_en && (kd_cur != in_data.pressed)) begin
      push_cmd.kind     = CMD_EVENT;
      push_cmd.ev_state = in_data.pressed ? KS_PRESSED : KS_RELEASED;
    end
  end

  // State update on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_r <= '0;
      for (int i = 0; i < NHOLD; i++) begin
        hold_st_r[i]    <= HS_IDLE;
        hold_start_r[i] <= '0;
      end
    end else if (accept) begin
      if (kd_en) begin
        key_down_r[pos[KEY_IDX_W-1:0]] <= in_data.pressed;
      end
      for (int i = 0; i < NHOLD; i++) begin
        if (fsm_en && (sel == HOLD_IDX_W'(i))) begin
          hold_st_r[i] <= hold_st_nxt;
          if (set_start) begin
            hold_start_r[i] <= in_data.now_ms;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kme_queue.sv
// Short command queue between the front end and the back end.
// Depends on kme_pkg for the entry type and depth.
`default_nettype none

module kme_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push_valid,
  output logic          push_ready,
  input  kme_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  wire           pop_ready,
  output kme_pkg::cmd_t pop_cmd
);
  import kme_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kme_back.sv
// Back end: expands queued commands into result items in an output register.
// A power pulse command gives two results. Depends on kme_pkg.
`default_nettype none

module kme_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                pop_valid,
  output logic               pop_ready,
  input  kme_pkg::cmd_t      pop_cmd,
  output logic               out_valid,
  input  wire                out_ready,
  output kme_pkg::out_item_t out_data
);
  import kme_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      beat_r;
  logic      load;
  out_item_t item_nxt;
  logic      beat_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || out_ready;

  // Build the next result from the queue head.
  always_comb begin
    item_nxt  = '0;
    beat_nxt  = 1'b0;
    pop_ready = load;
    item_nxt.last = 1'b1;
    case (pop_cmd.kind)
      CMD_EVENT: begin
        item_nxt.event_valid = 1'b1;
        item_nxt.keycode     = pop_cmd.keycode;
        item_nxt.ev_state    = pop_cmd.ev_state;
      end
      CMD_POR: begin
        item_nxt.power_on_request = 1'b1;
      end
      CMD_PULSE: begin
        item_nxt.event_valid = 1'b1;
        item_nxt.keycode     = KC_POWER;
        if (!beat_r) begin
          // Press first; the entry stays for the release.
          item_nxt.ev_state = KS_PRESSED;
          item_nxt.last     = 1'b0;
          beat_nxt          = 1'b1;
          pop_ready         = 1'b0;
        end else begin
          item_nxt.ev_state = KS_RELEASED;
        end
      end
      default: begin
        item_nxt.last = 1'b1;
      end
    endcase
  end

  // Output register and pulse beat tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= 1'b0;
    end else if (load) begin
      out_valid_r <= pop_valid;
      if (pop_valid) begin
        beat_r <= beat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      out_data_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/key_matrix_event_generator.sv
// Top level of the key matrix event generator: configuration registers,
// front end, command queue and back end. Depends on kme_pkg and all kme_ modules.
//
// One key sample is taken per cycle while the queue has room. The front end
// looks the position up in the keycode ROM, advances the per-key or hold
// state in the same cycle and queues one command; the command is registered
// in the queue and the result then in the registered output. Each sample
// gives one result, except a power long hold with the driver loaded, which
// gives a press and then a release and so occupies the output for both.
// A four-entry queue lets the input keep moving while the output is stalled.
// Configuration writes take effect on the next cycle; indexes beyond the
// register list are ignored.
`default_nettype none

module key_matrix_event_generator #(
  parameter int ROWS = 7,
  parameter int COLS = 6
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [kme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [kme_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  kme_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output kme_pkg::out_item_t                 out_data
);
  import kme_pkg::*;

  cfg_t cfg_r;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time_tens_ms <= HOLD_TIME_RST;
      cfg_r.pwr_hold_ms       <= LONG_HOLD_RST;
      cfg_r.driver_loaded     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_TIME:     cfg_r.hold_time_tens_ms <= cfg_wdata[7:0];
        CFG_LONG_HOLD:     cfg_r.pwr_hold_ms       <= cfg_wdata[15:0];
        CFG_DRIVER_LOADED: cfg_r.driver_loaded     <= cfg_wdata[0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  kme_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  kme_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  kme_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> test/key_matrix_event_generator_tb.sv
// Self-checking testbench for key_matrix_event_generator: key samples over a
// valid/ready channel, results checked against an in-bench event predictor.
// Depends on kme_pkg and the key_matrix_event_generator RTL.
`default_nettype none

module key_matrix_event_generator_tb;
  import kme_pkg::*;

  localparam int ROWS = 7;
  localparam int COLS = 6;
  // Index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Predicts the events of each accepted key sample and holds them in order.
  class key_event_board;
    logic [7:0]  hold_tens;
    logic [15:0] long_ms;
    logic        drv_loaded;
    bit          key_is_down [MAP_SIZE];
    hold_st_t    hstate [NHOLD];
    logic [31:0] hstart [NHOLD];
    out_item_t   expected_events [$];
    int          errors;

    function new();
      hold_tens  = HOLD_TIME_RST;
      long_ms    = LONG_HOLD_RST;
      drv_loaded = 1'b0;
      errors     = 0;
      foreach (key_is_down[i]) key_is_down[i] = 1'b0;
      foreach (hstate[i]) begin
        hstate[i] = HS_IDLE;
        hstart[i] = '0;
      end
    endfunction

    // Hold machine slot of a modifier keycode, or -1 for any other key.
    static function int modifier_slot(logic [7:0] code);
      int slot;
      case (code)
        KC_LSHIFT: slot = HIDX_LSHIFT;
        KC_RSHIFT: slot = HIDX_RSHIFT;
        KC_LALT:   slot = HIDX_LALT;
        KC_RALT:   slot = HIDX_RALT;
        default:   slot = -1;
      endcase
      return slot;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HOLD_TIME:     hold_tens = val[7:0];
        CFG_LONG_HOLD:     long_ms = val;
        CFG_DRIVER_LOADED: drv_loaded = val[0];
        default: ;
      endcase
    endfunction

    // One step of a hold machine; flags the power long-hold actions.
    function void step_hold(int idx, logic down, logic [31:0] now,
                            output logic por, output logic pulse);
      logic [31:0] held;
      logic [31:0] hold_limit;
      por        = 1'b0;
      pulse      = 1'b0;
      held       = now - hstart[idx];
      hold_limit = {24'd0, hold_tens} * 32'd10;
      case (hstate[idx])
        HS_IDLE: begin
          if (down) begin
            hstate[idx] = HS_PRESSED;
            hstart[idx] = now;
          end
        end
        HS_PRESSED: begin
          // The threshold wins over a release seen in the same sample.
          if (held > hold_limit) hstate[idx] = HS_HOLD;
          else if (!down) hstate[idx] = HS_RELEASED;
        end
        HS_HOLD: begin
          if (!down) begin
            hstate[idx] = HS_RELEASED;
          end else if (idx == HIDX_POWER) begin
            if (!drv_loaded) begin
              por = 1'b1;
              hstate[idx] = HS_LONG;
            end else if (held > {16'd0, long_ms}) begin
              pulse = 1'b1;
              hstate[idx] = HS_LONG;
            end
          end
        end
        HS_LONG: begin
          if (!down) hstate[idx] = HS_RELEASED;
        end
        default: hstate[idx] = HS_IDLE;
      endcase
    endfunction

    function out_item_t make_event(logic ev, logic [7:0] code, logic [2:0] ks, logic por);
      out_item_t r;
      r.event_valid      = ev;
      r.keycode          = code;
      r.ev_state         = ks;
      r.power_on_request = por;
      r.last             = 1'b0;
      return r;
    endfunction

    // Work out the events of one accepted sample.
    function void note_sample(in_item_t s);
      out_item_t   evs [2];
      int          n;
      int          pos;
      int          slot;
      logic [7:0]  code;
      logic        por;
      logic        pulse;
      hold_st_t    was;
      n = 0;
      if (s.opcode == OP_POWER) begin
        step_hold(HIDX_POWER, s.pressed, s.now_ms, por, pulse);
        if (pulse) begin
          evs[0] = make_event(1'b1, KC_POWER, KS_PRESSED, 1'b0);
          evs[1] = make_event(1'b1, KC_POWER, KS_RELEASED, 1'b0);
          n = 2;
        end else if (por) begin
          evs[0] = make_event(1'b0, KC_NONE, KS_IDLE, 1'b1);
          n = 1;
        end
      end else if (s.row < ROWS && s.col < COLS) begin
        pos  = s.row * COLS + s.col;
        code = KEYMAP[pos];
        if (code != KC_NONE && code != KC_POWER) begin
          slot = modifier_slot(code);
          if (slot >= 0) begin
            was = hstate[slot];
            step_hold(slot, s.pressed, s.now_ms, por, pulse);
            if (hstate[slot] != was) begin
              if (hstate[slot] == HS_PRESSED) begin
                evs[0] = make_event(1'b1, code, KS_PRESSED, 1'b0);
                n = 1;
              end else if (hstate[slot] == HS_HOLD) begin
                evs[0] = make_event(1'b1, code, KS_HOLD, 1'b0);
                n = 1;
              end else if (hstate[slot] == HS_RELEASED) begin
                evs[0] = make_event(1'b1, code, KS_RELEASED, 1'b0);
                n = 1;
              end
            end
          end else begin
            if (key_is_down[pos] != s.pressed) begin
              evs[0] = make_event(1'b1, code, s.pressed ? KS_PRESSED : KS_RELEASED, 1'b0);
              n = 1;
            end
            key_is_down[pos] = s.pressed;
          end
        end
      end
      // A sample that reports nothing still gives one empty result.
      if (n == 0) begin
        evs[0] = make_event(1'b0, KC_NONE, KS_IDLE, 1'b0);
        n = 1;
      end
      evs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_events.push_back(evs[i]);
    endfunction

    function void field_mismatch(string name, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endfunction

    // Compare one result transfer with the oldest expected event.
    function void check_event(out_item_t got);
      out_item_t want;
      if (expected_events.size() == 0) begin
        errors++;
        $display({"%0t: unexpected result, expected none, ",
                  "actual ev=%0h code=%0h st=%0h por=%0h last=%0h"},
                 $time, got.event_valid, got.keycode, got.ev_state,
                 got.power_on_request, got.last);
        return;
      end
      want = expected_events.pop_front();
      if (got.event_valid !== want.event_valid)
        field_mismatch("event_valid", 8'(want.event_valid), 8'(got.event_valid));
      if (got.keycode !== want.keycode)
        field_mismatch("keycode", want.keycode, got.keycode);
      if (got.ev_state !== want.ev_state)
        field_mismatch("ev_state", 8'(want.ev_state), 8'(got.ev_state));
      if (got.power_on_request !== want.power_on_request)
        field_mismatch("power_on_request", 8'(want.power_on_request),
                       8'(got.power_on_request));
      if (got.last !== want.last)
        field_mismatch("last", 8'(want.last), 8'(got.last));
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  key_event_board sb = new();

  int          tx_idle;
  int          rx_idle;
  int          step_max;
  int          live_items;
  logic [31:0] wall_ms;
  int          mod_pos [4];

  key_matrix_event_generator #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: ready changes on the falling edge with the current stall rate.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Every result transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_event(out_data);
  end

  function automatic in_item_t key_sample(logic op, logic [2:0] row, logic [2:0] col,
                                          logic pr, logic [31:0] now);
    in_item_t s;
    s.opcode  = op;
    s.row     = row;
    s.col     = col;
    s.pressed = pr;
    s.now_ms  = now;
    return s;
  endfunction

  // Offer one sample and hold it until the transfer; starts and ends at a falling edge.
  task automatic send_sample(input in_item_t s);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic send_matrix(input int pos, input logic pr, input logic [31:0] now);
    send_sample(key_sample(OP_MATRIX, 3'(pos / COLS), 3'(pos % COLS), pr, now));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Stop offering samples and wait until every expected event has come out.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  // A press, a few held samples, a release and a trailing sample, with the odd
  // level flipped to break the sequence.
  task automatic run_episode(input logic op, input int pos);
    int   len;
    logic pr;
    len = $urandom_range(1, 6);
    for (int k = 0; k <= len + 1; k++) begin
      if (k < len) pr = 1'b1;
      else if (k == len) pr = 1'b0;
      else pr = 1'($urandom_range(1));
      if ($urandom_range(9) == 0) pr = ~pr;
      wall_ms += $urandom_range(step_max);
      if (op == OP_POWER)
        send_sample(key_sample(OP_POWER, 3'($urandom_range(7)), 3'($urandom_range(7)),
                               pr, wall_ms));
      else
        send_matrix(pos, pr, wall_ms);
      live_items++;
    end
  endtask

  // One setting of the registers and the idle rates, then random traffic.
  task automatic run_phase(input logic [7:0] hold, input logic [15:0] long_hold,
                           input logic drv, input int step, input int tx, input int rx,
                           input int target);
    int       pick;
    int       pos;
    in_item_t s;
    drain();
    write_reg(CFG_HOLD_TIME, {8'd0, hold});
    write_reg(CFG_LONG_HOLD, long_hold);
    write_reg(CFG_DRIVER_LOADED, {15'd0, drv});
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
    tx_idle    = tx;
    rx_idle    = rx;
    step_max   = step;
    wall_ms    = $urandom;
    live_items = 0;
    while (live_items < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        run_episode(OP_MATRIX, mod_pos[$urandom_range(3)]);
      end else if (pick < 65) begin
        run_episode(OP_POWER, 0);
      end else if (pick < 88) begin
        // Ordinary key with a random level.
        do pos = $urandom_range(MAP_SIZE - 1);
        while (KEYMAP[pos] == KC_NONE || key_event_board::modifier_slot(KEYMAP[pos]) >= 0);
        wall_ms += $urandom_range(step_max);
        send_matrix(pos, 1'($urandom_range(1)), wall_ms);
        live_items++;
      end else begin
        // Noise: any position, any kind, sometimes an unrelated timestamp.
        s = key_sample(1'($urandom_range(1)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                       1'($urandom_range(1)), $urandom_range(1) ? wall_ms : $urandom);
        send_sample(s);
      end
    end
  endtask

  initial begin
    int slot;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    tx_idle   = 16;
    rx_idle   = 76;
    step_max  = 0;
    wall_ms   = '0;
    for (int p = 0; p < MAP_SIZE; p++) begin
      slot = key_event_board::modifier_slot(KEYMAP[p]);
      if (slot >= 0) mod_pos[slot] = p;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset settings: 300 ms hold, 1000 ms long hold,
    // driver not loaded.
    send_matrix(0, 1'b1, 32'hFFFF_FFFF);
    send_matrix(0, 1'b0, 32'd5);
    send_matrix(0, 1'b0, 32'd6);
    send_matrix(COLS, 1'b1, 32'd7);
    send_sample(key_sample(OP_MATRIX, 3'd7, 3'd0, 1'b1, 32'd8));
    send_sample(key_sample(OP_MATRIX, 3'd0, 3'd7, 1'b1, 32'd9));
    send_sample(key_sample(OP_MATRIX, 3'd7, 3'd7, 1'b1, 32'd10));
    // Left shift through pressed, hold and released; no long hold for modifiers.
    send_matrix(mod_pos[HIDX_LSHIFT], 1'b1, 32'd100);
    send_matrix(mod_pos[HIDX_LSHIFT], 1'b1, 32'd401);
    send_matrix(mod_pos[HIDX_LSHIFT], 1'b1, 32'd5000);
    send_matrix(mod_pos[HIDX_LSHIFT], 1'b0, 32'd5001);
    send_matrix(mod_pos[HIDX_LSHIFT], 1'b0, 32'd5002);
    // Right shift released exactly at the threshold, then a press only returns to idle.
    send_matrix(mod_pos[HIDX_RSHIFT], 1'b1, 32'd6000);
    send_matrix(mod_pos[HIDX_RSHIFT], 1'b0, 32'd6300);
    send_matrix(mod_pos[HIDX_RSHIFT], 1'b1, 32'd6310);
    // Left alt across the timestamp wrap: hold wins over the release in the same sample.
    send_matrix(mod_pos[HIDX_LALT], 1'b1, 32'hFFFF_FF00);
    send_matrix(mod_pos[HIDX_LALT], 1'b0, 32'h0000_0040);
    send_matrix(mod_pos[HIDX_LALT], 1'b0, 32'h0000_0041);
    send_matrix(mod_pos[HIDX_RALT], 1'b1, 32'd7000);
    send_matrix(mod_pos[HIDX_RALT], 1'b0, 32'd7001);
    // Power button with the driver unloaded raises a power-on request.
    send_sample(key_sample(OP_POWER, 3'd0, 3'd0, 1'b1, 32'd10000));
    send_sample(key_sample(OP_POWER, 3'd5, 3'd2, 1'b1, 32'd10400));
    send_sample(key_sample(OP_POWER, 3'd7, 3'd7, 1'b1, 32'd10401));
    send_sample(key_sample(OP_POWER, 3'd2, 3'd5, 1'b0, 32'd10402));
    send_sample(key_sample(OP_POWER, 3'd0, 3'd0, 1'b1, 32'd10403));

    // Random part: sender idles lightly and receiver heavily, then the reverse,
    // then no idling at all.
    run_phase(8'd0,   16'd0,     1'b1, 3,     16, 76, 65);
    run_phase(8'd5,   16'd200,   1'b0, 20,    16, 76, 65);
    run_phase(8'd255, 16'd65535, 1'b1, 12000, 76, 16, 65);
    run_phase(8'd2,   16'd150,   1'b1, 40,    76, 16, 65);
    run_phase(8'd20,  16'd300,   1'b1, 80,    0,  0,  65);
    run_phase(8'd255, 16'd0,     1'b0, 700,   0,  0,  65);

    drain();
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
